// ===== sv/pas_pkg.sv =====
// Shared types, constants and altitude table functions for the pressure altimeter sequencer.
`default_nettype none
package pas_pkg;

    localparam int PA_W      = 17;
    localparam int ALT_W     = 24;
    localparam int DLY_W     = 16;
    localparam int CYC_W     = 8;
    localparam int GND_W     = 32;
    localparam int ACT_W     = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE   = 3'd0,
        ACT_TSTART = 3'd1,
        ACT_TREAD  = 3'd2,
        ACT_TGET   = 3'd3,
        ACT_PSTART = 3'd4,
        ACT_PREAD  = 3'd5,
        ACT_PGET   = 3'd6
    } t_action;

    localparam logic [MODE_W-1:0] MODE_POLL       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL_CAL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GROUND_CAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_CAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_CAL  = 3'd4;

    localparam logic [DLY_W-1:0] IDLE_SLEEP         = 16'd1000;
    localparam logic [DLY_W-1:0] TEMP_DELAY_RESET   = 16'd1000;
    localparam logic [DLY_W-1:0] PRESS_DELAY_RESET  = 16'd1000;
    localparam logic [CYC_W-1:0] FULL_CAL_RESET     = 8'd100;
    localparam logic [CYC_W-1:0] GROUND_CAL_RESET   = 8'd10;

    localparam logic [63:0] Q30_ONE      = 64'h0000_0000_4000_0000;
    localparam logic [63:0] EXP_Q30      = 64'd204327700;
    localparam logic [63:0] SEA_LEVEL_PA = 64'd101325;
    localparam int          ALT_SCALE    = 4433000;

    function automatic logic [63:0] pas_isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = '0;
        for (int s = 31; s >= 0; s--) begin
            b = 64'd1 << (2 * s);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic longint pas_log2_q30(input logic [63:0] y);
        int          m;
        logic [63:0] mant;
        logic [63:0] frac;
        m = 0;
        for (int j = 1; j < 64; j++) begin
            if (y[j]) begin
                m = j;
            end
        end
        mant = (m >= 30) ? (y >> (m - 30)) : (y << (30 - m));
        frac = '0;
        for (int i = 1; i <= 30; i++) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd2 << 30)) begin
                mant = mant >> 1;
                frac = frac | (64'd1 << (30 - i));
            end
        end
        return longint'((64'(m) << 30) + frac);
    endfunction

    function automatic int pas_alt_node(input int k, input int pbits, input longint ld);
        longint      lv;
        longint      ip;
        longint      sv;
        logic [63:0] mag;
        logic [63:0] em;
        logic [63:0] f;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] root;
        logic [63:0] v_mag;
        logic [63:0] scaled;
        int          node;
        if (k == 0) begin
            node = ALT_SCALE;
        end else begin
            lv  = pas_log2_q30(64'(k) << pbits) - ld;
            mag = (lv < 0) ? 64'(-lv) : 64'(lv);
            em  = (mag * EXP_Q30 + (Q30_ONE >> 1)) >> 30;
            if (lv < 0) begin
                q  = (em + Q30_ONE - 64'd1) >> 30;
                f  = (q << 30) - em;
                ip = -longint'(q);
            end else begin
                ip = longint'(em >> 30);
                f  = em & (Q30_ONE - 64'd1);
            end
            p    = Q30_ONE;
            root = '0;
            for (int i = 1; i <= 30; i++) begin
                root = (i == 1) ? pas_isqrt64(64'd1 << 61) : pas_isqrt64(root << 30);
                if (f[30 - i]) begin
                    p = (p * root) >> 30;
                end
            end
            if (ip >= 0) begin
                p = p << ((ip > 8) ? 8 : ip);
            end else begin
                p = (-ip >= 63) ? 64'd0 : (p >> (-ip));
            end
            sv     = longint'(Q30_ONE) - longint'(p);
            v_mag  = (sv < 0) ? 64'(-sv) : 64'(sv);
            scaled = (v_mag * 64'(ALT_SCALE) + (Q30_ONE >> 1)) >> 30;
            node   = (sv < 0) ? -int'(scaled) : int'(scaled);
        end
        return node;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pas_alt_rom.sv =====
// Altitude table ROM with registered read, nodes fixed at elaboration.
`default_nettype none
module pas_alt_rom #(
    parameter int ENTRIES = 1024,
    parameter int PBITS   = 17
) (
    input  wire logic                                 i_clk,
    input  wire logic [$clog2(ENTRIES + 1)-1:0]       i_addr,
    output logic signed [pas_pkg::ALT_W-1:0]          o_data
);
    import pas_pkg::*;

    localparam longint LD = pas_log2_q30(64'(ENTRIES) * SEA_LEVEL_PA);

    logic signed [ALT_W-1:0] w_rom [0:ENTRIES];
    logic signed [ALT_W-1:0] r_data;

    for (genvar k = 0; k <= ENTRIES; k++) begin : g_node
        localparam int NODE = pas_alt_node(k, PBITS, LD);
        assign w_rom[k] = ALT_W'(NODE);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

// ===== sv/pas_serial_mul.sv =====
// Bit-serial shift-add multiplier returning the product scaled down by the multiplier width.
`default_nettype none
module pas_serial_mul #(
    parameter int MW = 25,
    parameter int NW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_mcand,
    input  wire logic [NW-1:0] i_mplier,
    output logic               o_done,
    output logic [MW-1:0]      o_prod
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_acc;
    logic [MW-1:0] r_mcand;
    logic [NW-1:0] r_mpl;
    logic [MW:0]   w_sum;

    always_comb begin
        w_sum = {1'b0, r_acc} + (r_mpl[0] ? {1'b0, r_mcand} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_mcand <= i_mcand;
            r_mpl   <= i_mplier;
        end else if (r_busy) begin
            r_acc <= w_sum[MW:1];
            r_mpl <= r_mpl >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// ===== sv/pas_serial_div.sv =====
// Bit-serial restoring divider for unsigned dividend and divisor.
`default_nettype none
module pas_serial_div #(
    parameter int DW = 33,
    parameter int VW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   w_shift;
    logic [VW+1:0] w_diff;
    logic          w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
        w_ge    = !w_diff[VW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// ===== sv/pressure_altimeter_sequencer.sv =====
// Top level: sensor sequencer, altitude interpolation and ground calibration.
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready  | mode, bus_busy, device_done, pressure_pa
//  out     | output    | o_out_valid / i_out_ready| action, sleep_us, altitude_valid,
//          |           |                          | altitude_cm, calibrated
//  cfg     | input     | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
// A word that completes no pressure sample goes from accept to the done state and back
// to idle. A completed pressure sample also passes ROM_LO, ROM_HI, MUL_GO, MUL and CAL,
// waiting in MUL for the bit-serial interpolation multiplier; a word that finishes ground
// calibration also waits in DIV for the bit-serial divider. The table ROM is read twice,
// one registered read each. Synchronous active-low reset; no clearing pass. A result
// waits in the output register while the next word is accepted and worked on.
`default_nettype none
module pressure_altimeter_sequencer #(
    parameter int ALT_TABLE_ENTRIES = 1024,
    parameter int PRESSURE_BITS     = 17
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [pas_pkg::MODE_W-1:0]        i_mode,
    input  wire logic                              i_bus_busy,
    input  wire logic                              i_device_done,
    input  wire logic [pas_pkg::PA_W-1:0]          i_pressure_pa,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [pas_pkg::ACT_W-1:0]              o_action,
    output logic [pas_pkg::DLY_W-1:0]              o_sleep_us,
    output logic                                   o_altitude_valid,
    output logic signed [pas_pkg::ALT_W-1:0]       o_altitude_cm,
    output logic                                   o_calibrated,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pas_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import pas_pkg::*;

    localparam int PB = PRESSURE_BITS;
    localparam int AW = $clog2(ALT_TABLE_ENTRIES + 1);
    localparam int TW = PB + AW;
    localparam int MW = ALT_W + 1;
    localparam int SW = GND_W + 1;

    typedef enum logic [2:0] {
        SEQ_PSTART  = 3'd0,
        SEQ_PREAD   = 3'd1,
        SEQ_PSAMPLE = 3'd2,
        SEQ_TSTART  = 3'd3,
        SEQ_TREAD   = 3'd4,
        SEQ_TSAMPLE = 3'd5
    } t_seq;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROM_LO,
        ST_ROM_HI,
        ST_MUL_GO,
        ST_MUL,
        ST_CAL,
        ST_DIV,
        ST_DONE
    } t_state;

    // control state
    t_state           r_state,       n_state;
    t_seq             r_seq,         n_seq;
    logic [DLY_W-1:0] r_temp_delay,  n_temp_delay;
    logic [DLY_W-1:0] r_press_delay, n_press_delay;
    logic             r_combined,    n_combined;
    logic [CYC_W-1:0] r_full_cyc,    n_full_cyc;
    logic [CYC_W-1:0] r_ground_cyc,  n_ground_cyc;
    logic [CYC_W-1:0] r_cal_target,  n_cal_target;
    logic [CYC_W-1:0] r_cal_count,   n_cal_count;
    logic [GND_W-1:0] r_ground,      n_ground;
    logic             r_is_cal,      n_is_cal;
    logic             r_out_valid,   n_out_valid;

    // payload
    logic [AW-1:0]           r_idx,        n_idx;
    logic [PB-1:0]           r_frac,       n_frac;
    logic signed [ALT_W-1:0] r_a,          n_a;
    logic                    r_d_neg,      n_d_neg;
    logic signed [ALT_W-1:0] r_alt,        n_alt;
    logic                    r_sum_neg,    n_sum_neg;
    t_action                 r_res_action, n_res_action;
    logic [DLY_W-1:0]        r_res_sleep,  n_res_sleep;
    logic                    r_res_valid,  n_res_valid;
    logic signed [ALT_W-1:0] r_res_alt,    n_res_alt;
    t_action                 r_out_action, n_out_action;
    logic [DLY_W-1:0]        r_out_sleep,  n_out_sleep;
    logic                    r_out_avalid, n_out_avalid;
    logic signed [ALT_W-1:0] r_out_alt,    n_out_alt;
    logic                    r_out_cal,    n_out_cal;

    logic                    w_accept;
    logic [PB-1:0]           w_pa;
    logic [TW-1:0]           w_t;
    logic [AW-1:0]           w_rom_addr;
    logic signed [ALT_W-1:0] w_rom_q;
    logic [MW-1:0]           w_diff;
    logic [MW-1:0]           w_mag;
    logic                    w_mul_start;
    logic                    w_mul_done;
    logic [MW-1:0]           w_prod;
    logic [MW-1:0]           w_a_ext;
    logic [MW-1:0]           w_interp;
    logic [SW-1:0]           w_alt_ext;
    logic [SW-1:0]           w_gnd_ext;
    logic [SW-1:0]           w_sum;
    logic [SW-1:0]           w_sum_mag;
    logic [SW-1:0]           w_rel;
    logic [SW-ALT_W:0]       w_rel_hi;
    logic signed [ALT_W-1:0] w_rel_sat;
    logic [CYC_W-1:0]        w_count_inc;
    logic                    w_cal_hit;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [SW-1:0]           w_quot;
    logic [SW-1:0]           w_quot_s;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_pa        = PB'(i_pressure_pa);
    assign w_t         = TW'(w_pa) * TW'(ALT_TABLE_ENTRIES);
    assign w_rom_addr  = (r_state == ST_ROM_HI) ? r_idx + AW'(1) : r_idx;
    assign w_diff      = {r_a[ALT_W-1], r_a} - {w_rom_q[ALT_W-1], w_rom_q};
    assign w_mag       = w_diff[MW-1] ? -w_diff : w_diff;
    assign w_mul_start = (r_state == ST_MUL_GO);
    assign w_a_ext     = {r_a[ALT_W-1], r_a};
    assign w_interp    = r_d_neg ? w_a_ext + w_prod : w_a_ext - w_prod;
    assign w_alt_ext   = {{(SW - ALT_W){r_alt[ALT_W-1]}}, r_alt};
    assign w_gnd_ext   = {r_ground[GND_W-1], r_ground};
    assign w_sum       = w_gnd_ext + w_alt_ext;
    assign w_sum_mag   = w_sum[SW-1] ? -w_sum : w_sum;
    assign w_rel       = w_alt_ext - w_gnd_ext;
    assign w_rel_hi    = w_rel[SW-1:ALT_W-1];
    assign w_count_inc = (r_cal_count == '1) ? r_cal_count : r_cal_count + CYC_W'(1);
    assign w_cal_hit   = (w_count_inc >= r_cal_target);
    assign w_div_start = (r_state == ST_CAL) && !r_is_cal && w_cal_hit;
    assign w_quot_s    = r_sum_neg ? -w_quot : w_quot;

    always_comb begin
        if ((&w_rel_hi) || !(|w_rel_hi)) begin
            w_rel_sat = w_rel[ALT_W-1:0];
        end else if (w_rel[SW-1]) begin
            w_rel_sat = {1'b1, {(ALT_W - 1){1'b0}}};
        end else begin
            w_rel_sat = {1'b0, {(ALT_W - 1){1'b1}}};
        end
    end

    pas_alt_rom #(
        .ENTRIES (ALT_TABLE_ENTRIES),
        .PBITS   (PRESSURE_BITS)
    ) u_alt_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_q)
    );

    pas_serial_mul #(
        .MW (MW),
        .NW (PB)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mag),
        .i_mplier (r_frac),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    pas_serial_div #(
        .DW (SW),
        .VW (CYC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_mag),
        .i_divisor  (w_count_inc),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state       = r_state;
        n_seq         = r_seq;
        n_temp_delay  = r_temp_delay;
        n_press_delay = r_press_delay;
        n_combined    = r_combined;
        n_full_cyc    = r_full_cyc;
        n_ground_cyc  = r_ground_cyc;
        n_cal_target  = r_cal_target;
        n_cal_count   = r_cal_count;
        n_ground      = r_ground;
        n_is_cal      = r_is_cal;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_idx         = r_idx;
        n_frac        = r_frac;
        n_a           = r_a;
        n_d_neg       = r_d_neg;
        n_alt         = r_alt;
        n_sum_neg     = r_sum_neg;
        n_res_action  = r_res_action;
        n_res_sleep   = r_res_sleep;
        n_res_valid   = r_res_valid;
        n_res_alt     = r_res_alt;
        n_out_action  = r_out_action;
        n_out_sleep   = r_out_sleep;
        n_out_avalid  = r_out_avalid;
        n_out_alt     = r_out_alt;
        n_out_cal     = r_out_cal;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEMP_DELAY:  n_temp_delay  = i_cfg_data;
                CFG_PRESS_DELAY: n_press_delay = i_cfg_data;
                CFG_COMBINED:    n_combined    = i_cfg_data[0];
                CFG_FULL_CAL:    n_full_cyc    = i_cfg_data[CYC_W-1:0];
                CFG_GROUND_CAL:  n_ground_cyc  = i_cfg_data[CYC_W-1:0];
                default: begin
                end
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res_action = ACT_NONE;
                    n_res_sleep  = IDLE_SLEEP;
                    n_res_valid  = 1'b0;
                    n_res_alt    = '0;
                    n_state      = ST_DONE;
                    if (i_mode != MODE_POLL) begin
                        n_res_sleep = '0;
                        if (i_mode == MODE_FULL_CAL || i_mode == MODE_GROUND_CAL) begin
                            n_cal_target = (i_mode == MODE_FULL_CAL) ? r_full_cyc
                                                                     : r_ground_cyc;
                            n_ground     = '0;
                            n_is_cal     = 1'b0;
                        end
                    end else if (!i_bus_busy) begin
                        unique case (r_seq)
                            SEQ_PSTART: begin
                                n_res_action = ACT_PSTART;
                                n_res_sleep  = r_press_delay;
                                n_seq        = SEQ_PREAD;
                            end
                            SEQ_PREAD: begin
                                n_res_action = ACT_PREAD;
                                if (i_device_done) begin
                                    n_seq = SEQ_PSAMPLE;
                                end
                            end
                            SEQ_PSAMPLE: begin
                                n_res_action = ACT_PGET;
                                if (i_device_done) begin
                                    n_res_valid = 1'b1;
                                    n_idx       = w_t[TW-1:PB];
                                    n_frac      = w_t[PB-1:0];
                                    n_seq       = r_combined ? SEQ_PSTART : SEQ_TSTART;
                                    n_state     = ST_ROM_LO;
                                end
                            end
                            SEQ_TREAD: begin
                                n_res_action = ACT_TREAD;
                                if (i_device_done) begin
                                    n_seq = SEQ_TSAMPLE;
                                end
                            end
                            SEQ_TSAMPLE: begin
                                n_res_action = ACT_TGET;
                                if (i_device_done) begin
                                    n_seq = SEQ_PSTART;
                                end
                            end
                            default: begin
                                n_res_action = ACT_TSTART;
                                n_res_sleep  = r_temp_delay;
                                n_seq        = SEQ_TREAD;
                            end
                        endcase
                    end
                end
            end
            ST_ROM_LO: begin
                n_state = ST_ROM_HI;
            end
            ST_ROM_HI: begin
                n_a     = w_rom_q;
                n_state = ST_MUL_GO;
            end
            ST_MUL_GO: begin
                n_d_neg = w_diff[MW-1];
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    n_alt   = w_interp[ALT_W-1:0];
                    n_state = ST_CAL;
                end
            end
            ST_CAL: begin
                if (r_is_cal) begin
                    n_res_alt = w_rel_sat;
                    n_state   = ST_DONE;
                end else if (w_cal_hit) begin
                    n_cal_count = '0;
                    n_is_cal    = 1'b1;
                    n_sum_neg   = w_sum[SW-1];
                    n_state     = ST_DIV;
                end else begin
                    n_cal_count = w_count_inc;
                    n_ground    = w_sum[GND_W-1:0];
                    n_state     = ST_DONE;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_ground = w_quot_s[GND_W-1:0];
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_action = r_res_action;
                    n_out_sleep  = r_res_sleep;
                    n_out_avalid = r_res_valid;
                    n_out_alt    = r_res_alt;
                    n_out_cal    = r_is_cal;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_seq         <= SEQ_PSTART;
            r_temp_delay  <= TEMP_DELAY_RESET;
            r_press_delay <= PRESS_DELAY_RESET;
            r_combined    <= 1'b0;
            r_full_cyc    <= FULL_CAL_RESET;
            r_ground_cyc  <= GROUND_CAL_RESET;
            r_cal_target  <= '0;
            r_cal_count   <= '0;
            r_ground      <= '0;
            r_is_cal      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_seq         <= n_seq;
            r_temp_delay  <= n_temp_delay;
            r_press_delay <= n_press_delay;
            r_combined    <= n_combined;
            r_full_cyc    <= n_full_cyc;
            r_ground_cyc  <= n_ground_cyc;
            r_cal_target  <= n_cal_target;
            r_cal_count   <= n_cal_count;
            r_ground      <= n_ground;
            r_is_cal      <= n_is_cal;
            r_out_valid   <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_frac       <= n_frac;
        r_a          <= n_a;
        r_d_neg      <= n_d_neg;
        r_alt        <= n_alt;
        r_sum_neg    <= n_sum_neg;
        r_res_action <= n_res_action;
        r_res_sleep  <= n_res_sleep;
        r_res_valid  <= n_res_valid;
        r_res_alt    <= n_res_alt;
        r_out_action <= n_out_action;
        r_out_sleep  <= n_out_sleep;
        r_out_avalid <= n_out_avalid;
        r_out_alt    <= n_out_alt;
        r_out_cal    <= n_out_cal;
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out_action;
    assign o_sleep_us       = r_out_sleep;
    assign o_altitude_valid = r_out_avalid;
    assign o_altitude_cm    = r_out_alt;
    assign o_calibrated     = r_out_cal;

endmodule
`default_nettype wire

// ===== sv/pas_checker.sv =====
// Port-level checks for the pressure altimeter sequencer, bound to the top level.
`default_nettype none
module pas_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [pas_pkg::ACT_W-1:0]         o_action,
    input wire logic [pas_pkg::DLY_W-1:0]         o_sleep_us,
    input wire logic                              o_altitude_valid,
    input wire logic signed [pas_pkg::ALT_W-1:0]  o_altitude_cm,
    input wire logic                              o_calibrated
);
    import pas_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    a_alt_only_on_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_altitude_valid) |-> (o_action == ACT_PGET))
        else $error("altitude produced without pressure sample action");

    a_no_alt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_altitude_valid) |-> (o_altitude_cm == '0))
        else $error("altitude nonzero without new sample");

    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_calibrated) |-> (o_altitude_cm == '0))
        else $error("altitude nonzero while calibrating");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_action) && $stable(o_sleep_us)
             && $stable(o_altitude_cm)))
        else $error("stalled output word changed");

endmodule

bind pressure_altimeter_sequencer pas_checker u_pas_checker (.*);
`default_nettype wire

// ===== verif/tb_pressure_altimeter_sequencer.sv =====
// Self-checking testbench for the pressure altimeter sequencer with its own altitude predictor.
`timescale 1ns / 1ps
module tb_pressure_altimeter_sequencer;
    import pas_pkg::*;

    localparam int TBL_N       = 1024;
    localparam int PBITS       = 17;
    localparam int HOLD_CYCLES = 300;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    typedef enum logic [2:0] {
        SQ_PSTART  = 3'd0,
        SQ_PREAD   = 3'd1,
        SQ_PSAMPLE = 3'd2,
        SQ_TSTART  = 3'd3,
        SQ_TREAD   = 3'd4,
        SQ_TSAMPLE = 3'd5
    } seq_e;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic              busy;
        logic              done;
        logic [PA_W-1:0]   pa;
    } poll_word_t;

    typedef struct {
        t_action                  action;
        logic [DLY_W-1:0]         sleep_us;
        logic                     alt_valid;
        logic signed [ALT_W-1:0]  alt_cm;
        logic                     calibrated;
    } poll_reply_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              busy;
        logic              done;
        logic [PA_W-1:0]   pa;
        logic              typed;
        t_action           act;
        logic [DLY_W-1:0]  sleep_us;
        logic              aval;
        logic [ALT_W-1:0]  alt;
        logic              cal;
    } dir_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [MODE_W-1:0]       i_mode;
    logic                    i_bus_busy;
    logic                    i_device_done;
    logic [PA_W-1:0]         i_pressure_pa;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [ACT_W-1:0]        o_action;
    logic [DLY_W-1:0]        o_sleep_us;
    logic                    o_altitude_valid;
    logic signed [ALT_W-1:0] o_altitude_cm;
    logic                    o_calibrated;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DAT_W-1:0]    i_cfg_data;

    pressure_altimeter_sequencer #(
        .ALT_TABLE_ENTRIES(TBL_N),
        .PRESSURE_BITS    (PBITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_bus_busy      (i_bus_busy),
        .i_device_done   (i_device_done),
        .i_pressure_pa   (i_pressure_pa),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_action        (o_action),
        .o_sleep_us      (o_sleep_us),
        .o_altitude_valid(o_altitude_valid),
        .o_altitude_cm   (o_altitude_cm),
        .o_calibrated    (o_calibrated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    int          alt_tbl [0:TBL_N];
    logic [63:0] root_tbl [1:30];

    logic [DLY_W-1:0] cfg_temp_dly;
    logic [DLY_W-1:0] cfg_press_dly;
    logic             cfg_combined;
    logic [CYC_W-1:0] cfg_full_cal;
    logic [CYC_W-1:0] cfg_ground_cal;
    seq_e             seq_now;
    logic [CYC_W-1:0] cal_goal;
    logic [CYC_W-1:0] sample_cnt;
    int               ground_acc;
    logic             is_cal;

    poll_reply_t poll_replies [$];
    poll_reply_t blank_reply;
    int          mismatch_cnt = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        rx_blocked = 1'b0;

    dir_row_t dir_tbl [25] = '{
        '{MODE_POLL, 1'b1, 1'b0, 17'd0, 1'b1, ACT_NONE, IDLE_SLEEP, 1'b0, 24'd0, 1'b0},
        '{MODE_NOP, 1'b0, 1'b0, 17'd0, 1'b1, ACT_NONE, 16'd0, 1'b0, 24'd0, 1'b0},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_PSTART, PRESS_DELAY_RESET, 1'b0, 24'd0, 1'b0},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_PREAD, IDLE_SLEEP, 1'b0, 24'd0, 1'b0},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_PREAD, IDLE_SLEEP, 1'b0, 24'd0, 1'b0},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_PGET, IDLE_SLEEP, 1'b0, 24'd0, 1'b0},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_PGET, IDLE_SLEEP, 1'b1, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_TSTART, TEMP_DELAY_RESET, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_TREAD, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_TGET, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_PSTART, PRESS_DELAY_RESET, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_PREAD, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_PGET, IDLE_SLEEP, 1'b1, 24'd0, 1'b1},
        '{MODE_POLL, 1'b1, 1'b1, 17'h1FFFF, 1'b1, ACT_NONE, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_TSTART, TEMP_DELAY_RESET, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_TREAD, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_TREAD, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_TGET, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_TGET, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b0, 17'd0, 1'b1, ACT_PSTART, PRESS_DELAY_RESET, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'd0, 1'b1, ACT_PREAD, IDLE_SLEEP, 1'b0, 24'd0, 1'b1},
        '{MODE_POLL, 1'b0, 1'b1, 17'h1FFFF, 1'b0, ACT_NONE, 16'd0, 1'b0, 24'd0, 1'b0},
        '{MODE_GROUND_CAL, 1'b1, 1'b0, 17'd0, 1'b1, ACT_NONE, 16'd0, 1'b0, 24'd0, 1'b0},
        '{MODE_FULL_CAL, 1'b0, 1'b1, 17'h1FFFF, 1'b1, ACT_NONE, 16'd0, 1'b0, 24'd0, 1'b0},
        '{MODE_NOP, 1'b1, 1'b1, 17'h1FFFF, 1'b1, ACT_NONE, 16'd0, 1'b0, 24'd0, 1'b0}
    };

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic longint log2_q30_of(input logic [63:0] y);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb = 63;
        while (msb > 0 && !y[msb]) begin
            msb--;
        end
        m    = (msb >= 30) ? (y >> (msb - 30)) : (y << (30 - msb));
        frac = '0;
        for (int i = 1; i <= 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | (64'd1 << (30 - i));
            end
        end
        return (longint'(msb) <<< 30) + longint'(frac);
    endfunction

    function automatic void build_alt_table();
        longint      ld;
        longint      lv;
        longint      ip;
        longint      dv;
        logic [63:0] mag;
        logic [63:0] em;
        logic [63:0] f;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] dm;
        logic [63:0] sc;
        root_tbl[1] = floor_sqrt(64'd1 << 61);
        for (int i = 2; i <= 30; i++) begin
            root_tbl[i] = floor_sqrt(root_tbl[i - 1] << 30);
        end
        ld = log2_q30_of(64'(TBL_N) * SEA_LEVEL_PA);
        alt_tbl[0] = ALT_SCALE;
        for (int k = 1; k <= TBL_N; k++) begin
            lv  = log2_q30_of(64'(k) << PBITS) - ld;
            mag = (lv < 0) ? 64'(-lv) : 64'(lv);
            em  = (mag * EXP_Q30 + (Q30_ONE >> 1)) >> 30;
            if (lv < 0) begin
                q  = (em + Q30_ONE - 64'd1) >> 30;
                f  = (q << 30) - em;
                ip = -longint'(q);
            end else begin
                ip = longint'(em >> 30);
                f  = em & (Q30_ONE - 64'd1);
            end
            p = Q30_ONE;
            for (int i = 1; i <= 30; i++) begin
                if (f[30 - i]) begin
                    p = (p * root_tbl[i]) >> 30;
                end
            end
            if (ip >= 0) begin
                p = p << ((ip > 8) ? 8 : ip);
            end else if (-ip >= 63) begin
                p = '0;
            end else begin
                p = p >> (-ip);
            end
            dv = longint'(Q30_ONE) - longint'(p);
            dm = (dv < 0) ? 64'(-dv) : 64'(dv);
            sc = (dm * 64'(ALT_SCALE) + (Q30_ONE >> 1)) >> 30;
            alt_tbl[k] = (dv < 0) ? -int'(sc) : int'(sc);
        end
    endfunction

    function automatic longint interp_alt(input logic [PA_W-1:0] pa);
        logic [63:0] t;
        logic [63:0] idx;
        logic [63:0] fr;
        longint      a;
        longint      d;
        longint      corr;
        t   = 64'(pa) * 64'(TBL_N);
        idx = t >> PBITS;
        fr  = t & ((64'd1 << PBITS) - 64'd1);
        if (idx >= TBL_N) begin
            idx = TBL_N - 1;
        end
        a = alt_tbl[idx];
        d = a - alt_tbl[idx + 1];
        if (d >= 0) begin
            corr = longint'((64'(d) * fr) >> PBITS);
        end else begin
            corr = -longint'((64'(-d) * fr) >> PBITS);
        end
        return a - corr;
    endfunction

    function automatic void reset_model();
        cfg_temp_dly   = TEMP_DELAY_RESET;
        cfg_press_dly  = PRESS_DELAY_RESET;
        cfg_combined   = 1'b0;
        cfg_full_cal   = FULL_CAL_RESET;
        cfg_ground_cal = GROUND_CAL_RESET;
        seq_now        = SQ_PSTART;
        cal_goal       = '0;
        sample_cnt     = '0;
        ground_acc     = 0;
        is_cal         = 1'b0;
    endfunction

    function automatic poll_reply_t predict_poll(input poll_word_t w);
        poll_reply_t r;
        longint      alt;
        longint      sum;
        r.action    = ACT_NONE;
        r.sleep_us  = IDLE_SLEEP;
        r.alt_valid = 1'b0;
        alt         = 0;
        if (w.mode != MODE_POLL) begin
            if (w.mode == MODE_FULL_CAL || w.mode == MODE_GROUND_CAL) begin
                cal_goal   = (w.mode == MODE_FULL_CAL) ? cfg_full_cal : cfg_ground_cal;
                ground_acc = 0;
                is_cal     = 1'b0;
            end
            r.sleep_us = '0;
        end else if (!w.busy) begin
            case (seq_now)
                SQ_PSTART: begin
                    r.action   = ACT_PSTART;
                    r.sleep_us = cfg_press_dly;
                    seq_now    = SQ_PREAD;
                end
                SQ_PREAD: begin
                    r.action = ACT_PREAD;
                    if (w.done) begin
                        seq_now = SQ_PSAMPLE;
                    end
                end
                SQ_PSAMPLE: begin
                    r.action = ACT_PGET;
                    if (w.done) begin
                        alt         = interp_alt(w.pa);
                        r.alt_valid = 1'b1;
                        if (is_cal) begin
                            alt = alt - longint'(ground_acc);
                        end else begin
                            sum = longint'(ground_acc) + alt;
                            if (sample_cnt != 8'd255) begin
                                sample_cnt++;
                            end
                            if (sample_cnt >= cal_goal) begin
                                sum        = sum / longint'(sample_cnt);
                                is_cal     = 1'b1;
                                sample_cnt = '0;
                            end
                            ground_acc = int'(sum);
                            alt        = 0;
                        end
                        seq_now = cfg_combined ? SQ_PSTART : SQ_TSTART;
                    end
                end
                SQ_TREAD: begin
                    r.action = ACT_TREAD;
                    if (w.done) begin
                        seq_now = SQ_TSAMPLE;
                    end
                end
                SQ_TSAMPLE: begin
                    r.action = ACT_TGET;
                    if (w.done) begin
                        seq_now = SQ_PSTART;
                    end
                end
                default: begin
                    r.action   = ACT_TSTART;
                    r.sleep_us = cfg_temp_dly;
                    seq_now    = SQ_TREAD;
                end
            endcase
        end
        if (alt > 64'sd8388607) begin
            alt = 8388607;
        end
        if (alt < -64'sd8388608) begin
            alt = -8388608;
        end
        r.alt_cm     = ALT_W'(alt);
        r.calibrated = is_cal;
        return r;
    endfunction

    function automatic poll_word_t gen_word(input bit allow_cal, input int busy_pct,
                                            input int done_pct);
        poll_word_t w;
        int         sel;
        sel = $urandom_range(0, 99);
        if (allow_cal && sel < 2) begin
            w.mode = MODE_FULL_CAL;
        end else if (allow_cal && sel < 4) begin
            w.mode = MODE_GROUND_CAL;
        end else if (sel == 99) begin
            w.mode = MODE_NOP;
        end else begin
            w.mode = MODE_POLL;
        end
        w.busy = ($urandom_range(0, 99) < busy_pct);
        w.done = ($urandom_range(0, 99) < done_pct);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w.pa = PA_W'($urandom_range(70000, 108000));
            5, 6, 7:       w.pa = PA_W'($urandom_range(0, 131071));
            8:             w.pa = PA_W'($urandom_range(0, TBL_N - 1) << 7);
            default:       w.pa = $urandom_range(0, 1) ? 17'h1FFFF
                                                       : PA_W'($urandom_range(0, 300));
        endcase
        return w;
    endfunction

    task automatic push_word(input poll_word_t w, input bit typed, input poll_reply_t tres);
        poll_reply_t pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= w.mode;
        i_bus_busy    <= w.busy;
        i_device_done <= w.done;
        i_pressure_pa <= w.pa;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pred = predict_poll(w);
        poll_replies.push_back(typed ? tres : pred);
        @(negedge i_clk);
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (poll_replies.size() != 0);
    endtask

    task automatic program_regs(input int unsigned t_dly, input int unsigned p_dly,
                                input int unsigned comb, input int unsigned full_n,
                                input int unsigned gnd_n);
        logic [CFG_DAT_W-1:0] val [5];
        logic [CFG_IDX_W-1:0] idx [5];
        idx[0] = CFG_TEMP_DELAY;
        idx[1] = CFG_PRESS_DELAY;
        idx[2] = CFG_COMBINED;
        idx[3] = CFG_FULL_CAL;
        idx[4] = CFG_GROUND_CAL;
        val[0] = CFG_DAT_W'(t_dly);
        val[1] = CFG_DAT_W'(p_dly);
        val[2] = CFG_DAT_W'(comb);
        val[3] = CFG_DAT_W'(full_n);
        val[4] = CFG_DAT_W'(gnd_n);
        for (int r = 0; r < 5; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[r];
            i_cfg_data  <= val[r];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            case (idx[r])
                CFG_TEMP_DELAY:  cfg_temp_dly = val[r];
                CFG_PRESS_DELAY: cfg_press_dly = val[r];
                CFG_COMBINED:    cfg_combined = val[r][0];
                CFG_FULL_CAL:    cfg_full_cal = val[r][CYC_W-1:0];
                CFG_GROUND_CAL:  cfg_ground_cal = val[r][CYC_W-1:0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_blocked = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_blocked = 1'b0;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= !rx_blocked && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : reply_check
        poll_reply_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (poll_replies.size() == 0) begin
                $error("result word with nothing expected");
                mismatch_cnt++;
            end else begin
                e = poll_replies.pop_front();
                if (o_action !== e.action) begin
                    $error("action: expected %0d, got %0d", e.action, o_action);
                    mismatch_cnt++;
                end
                if (o_sleep_us !== e.sleep_us) begin
                    $error("sleep_us: expected %0d, got %0d", e.sleep_us, o_sleep_us);
                    mismatch_cnt++;
                end
                if (o_altitude_valid !== e.alt_valid) begin
                    $error("altitude_valid: expected %0d, got %0d", e.alt_valid,
                           o_altitude_valid);
                    mismatch_cnt++;
                end
                if (o_altitude_cm !== e.alt_cm) begin
                    $error("altitude_cm: expected %0d, got %0d", e.alt_cm, o_altitude_cm);
                    mismatch_cnt++;
                end
                if (o_calibrated !== e.calibrated) begin
                    $error("calibrated: expected %0d, got %0d", e.calibrated, o_calibrated);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        poll_word_t  w;
        poll_reply_t tres;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_POLL;
        i_bus_busy    = 1'b0;
        i_device_done = 1'b0;
        i_pressure_pa = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_TEMP_DELAY;
        i_cfg_data    = '0;
        build_alt_table();
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[i]) begin
            w.mode          = dir_tbl[i].mode;
            w.busy          = dir_tbl[i].busy;
            w.done          = dir_tbl[i].done;
            w.pa            = dir_tbl[i].pa;
            tres.action     = dir_tbl[i].act;
            tres.sleep_us   = dir_tbl[i].sleep_us;
            tres.alt_valid  = dir_tbl[i].aval;
            tres.alt_cm     = dir_tbl[i].alt;
            tres.calibrated = dir_tbl[i].cal;
            push_word(w, dir_tbl[i].typed, tres);
        end
        drain_replies();

        // wide delays, quick full calibration, no idling
        program_regs(0, 65535, 0, 1, 255);
        for (int n = 0; n < 200; n++) begin
            push_word(gen_word(1'b1, 10, 75), 1'b0, blank_reply);
        end
        drain_replies();

        // longest calibration in combined mode, receiver stalling
        stall_pct = 66;
        program_regs(65535, 0, 1, 255, 1);
        w      = gen_word(1'b0, 3, 95);
        w.mode = MODE_FULL_CAL;
        push_word(w, 1'b0, blank_reply);
        do begin
            push_word(gen_word(1'b0, 3, 95), 1'b0, blank_reply);
        end while (!is_cal);
        for (int n = 0; n < 60; n++) begin
            push_word(gen_word(1'b1, 10, 75), 1'b0, blank_reply);
        end
        drain_replies();

        stall_pct     = 0;
        send_idle_pct = 66;
        program_regs(1234, 4321, 0, 3, 7);
        for (int n = 0; n < 250; n++) begin
            push_word(gen_word(1'b1, 10, 75), 1'b0, blank_reply);
        end
        drain_replies();

        // hold the receiver off while words keep coming
        stall_pct     = 12;
        send_idle_pct = 12;
        program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 1), $urandom_range(1, 12), $urandom_range(1, 12));
        for (int n = 0; n < 200; n++) begin
            if (n == 40) begin
                hold_req = 1'b1;
            end
            push_word(gen_word(1'b1, 10, 75), 1'b0, blank_reply);
        end
        drain_replies();

        stall_pct     = 0;
        send_idle_pct = 0;
        program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 1), $urandom_range(1, 255), $urandom_range(1, 20));
        for (int n = 0; n < 200; n++) begin
            push_word(gen_word(1'b1, 10, 75), 1'b0, blank_reply);
        end
        drain_replies();

        repeat (64) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pas_pkg.sv
sv/pas_alt_rom.sv
sv/pas_serial_mul.sv
sv/pas_serial_div.sv
sv/pressure_altimeter_sequencer.sv
sv/pas_checker.sv
verif/tb_pressure_altimeter_sequencer.sv
